@@ rtl/opp_pkg.sv @@
// ----------------------------------------------------------------------------
// opp_pkg: shared types, constants and helpers of the onset peak picker
// Widths, ring geometry, register indexes and the item carried from the
// front part to the back part.
// ----------------------------------------------------------------------------
`default_nettype none

package opp_pkg;

   localparam int RingDepth = 32;
   localparam int RingAw    = (RingDepth > 1) ? $clog2(RingDepth) : 1;
   localparam int ModW      = (RingAw + 1 > 6) ? RingAw + 1 : 6;

   localparam int EnvW   = 16;
   localparam int CtlW   = 4;
   localparam int WideW  = 16;
   localparam int FrameW = 32;
   localparam int OffW   = 6;
   localparam int SpanW  = 5;
   localparam int SumW   = 21;
   localparam int ProdW  = 21;
   localparam int IdxW   = 3;

   localparam int QDepth = 2;
   localparam int QAw    = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int QCntW  = $clog2(QDepth + 1);

   localparam logic [IdxW-1:0] CsrPreMax  = 3'd0;
   localparam logic [IdxW-1:0] CsrPostMax = 3'd1;
   localparam logic [IdxW-1:0] CsrPreAvg  = 3'd2;
   localparam logic [IdxW-1:0] CsrPostAvg = 3'd3;
   localparam logic [IdxW-1:0] CsrMargin  = 3'd4;
   localparam logic [IdxW-1:0] CsrMinGap  = 3'd5;

   typedef struct packed {
      logic [CtlW-1:0]  pre_max;
      logic [CtlW-1:0]  post_max;
      logic [CtlW-1:0]  pre_avg;
      logic [CtlW-1:0]  post_avg;
      logic [WideW-1:0] margin;
      logic [WideW-1:0] min_gap;
   } cfg_type;

   typedef struct packed {
      logic [EnvW-1:0]   env_value;
      logic              warm;
      logic [FrameW-1:0] cand_frame;
   } item_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   function automatic logic [CtlW-1:0] max4(input logic [CtlW-1:0] a,
                                            input logic [CtlW-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [RingAw-1:0] next_slot(input logic [RingAw-1:0] p);
      return (p == RingAw'(RingDepth - 1)) ? '0 : p + 1'b1;
   endfunction

   // Slot that lies span entries behind newest, modulo the ring depth
   function automatic logic [RingAw-1:0] span_slot(input logic [RingAw-1:0] newest,
                                                   input logic [SpanW-1:0]  span);
      logic [ModW-1:0] x;
      logic [ModW-1:0] d;
      logic [ModW-1:0] w;
      x = ModW'(span);
      d = ModW'(RingDepth);
      for (int k = 0; k < 8; k++) begin
         if (x >= d) x = x - d;
      end
      w = ModW'(newest);
      if (w >= x) w = w - x;
      else        w = w + d - x;
      return w[RingAw-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/opp_front.sv @@
// ----------------------------------------------------------------------------
// opp_front: input side of the onset peak picker
// Accepts envelope items, counts frames and marks warm-up items before
// handing them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module opp_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire opp_pkg::cfg_type          cfg,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [opp_pkg::EnvW-1:0]  req_env_value,
   input  wire opp_pkg::queue_status_type q_stat,
   output logic                           q_push,
   output opp_pkg::item_type              q_item
);

   logic [opp_pkg::FrameW-1:0] frame_count_ff;
   logic [opp_pkg::FrameW-1:0] frame_count_in;
   logic [opp_pkg::CtlW-1:0]   delay;

   assign req_stall      = q_stat.full;
   assign q_push         = req_valid && !q_stat.full;
   assign delay          = opp_pkg::max4(cfg.post_max, cfg.post_avg);
   assign frame_count_in = frame_count_ff + 1'b1;

   // classify against the count as it stands once this frame is in
   always_comb begin
      q_item.env_value  = req_env_value;
      q_item.warm       = frame_count_in <= opp_pkg::FrameW'(delay);
      q_item.cand_frame = frame_count_in - opp_pkg::FrameW'(delay);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
      end else if (q_push) begin
         frame_count_ff <= frame_count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/opp_queue.sv @@
// ----------------------------------------------------------------------------
// opp_queue: short item queue between front and back parts
// Lets the front accept the next frame while the back still walks the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module opp_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire opp_pkg::item_type         push_item,
   input  wire logic                      pop,
   output opp_pkg::item_type              head_item,
   output opp_pkg::queue_status_type      stat
);

   opp_pkg::item_type          entry_ff [opp_pkg::QDepth];
   logic [opp_pkg::QAw-1:0]    wr_ptr_ff;
   logic [opp_pkg::QAw-1:0]    rd_ptr_ff;
   logic [opp_pkg::QCntW-1:0]  count_ff;

   function automatic logic [opp_pkg::QAw-1:0] bump(input logic [opp_pkg::QAw-1:0] p);
      return (p == opp_pkg::QAw'(opp_pkg::QDepth - 1)) ? '0 : p + 1'b1;
   endfunction

   assign head_item      = entry_ff[rd_ptr_ff];
   assign stat.full      = count_ff == opp_pkg::QCntW'(opp_pkg::QDepth);
   assign stat.not_empty = count_ff != '0;

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= bump(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= bump(rd_ptr_ff);
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

`default_nettype wire

@@ rtl/opp_back.sv @@
// ----------------------------------------------------------------------------
// opp_back: ring store and peak decision of the onset peak picker
// Writes each frame into the ring; outside warm-up, walks the window around
// the candidate one entry a cycle and applies the maximum, mean and gap tests.
// ----------------------------------------------------------------------------
`default_nettype none

module opp_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire opp_pkg::cfg_type          cfg,
   input  wire opp_pkg::queue_status_type q_stat,
   input  wire opp_pkg::item_type         q_item,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [opp_pkg::EnvW-1:0]       rsp_event_strength,
   output logic                           rsp_event_flag
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_EVAL,
      ST_DECIDE,
      ST_DONE
   } state_type;

   state_type                      state_ff;
   logic [opp_pkg::RingAw-1:0]     wp_ff;
   logic [opp_pkg::RingAw-1:0]     ptr_ff;
   logic signed [opp_pkg::OffW-1:0] off_ff;
   logic signed [opp_pkg::OffW-1:0] d_off_ff;
   logic                           d_valid_ff;
   logic                           issue_done_ff;
   logic [opp_pkg::EnvW-1:0]       max_ff;
   logic [opp_pkg::EnvW-1:0]       cand_ff;
   logic [opp_pkg::SumW-1:0]       sum_ff;
   logic [opp_pkg::ProdW-1:0]      prod_c_ff;
   logic [opp_pkg::ProdW-1:0]      prod_m_ff;
   logic [opp_pkg::FrameW-1:0]     cand_frame_ff;
   logic [opp_pkg::FrameW-1:0]     last_event_ff;
   logic                           have_event_ff;
   logic                           res_flag_ff;
   logic [opp_pkg::EnvW-1:0]       res_str_ff;
   logic                           rsp_valid_ff;
   logic [opp_pkg::EnvW-1:0]       rsp_str_ff;
   logic                           rsp_flag_ff;

   logic [opp_pkg::EnvW-1:0]       ring_mem [opp_pkg::RingDepth];
   logic [opp_pkg::RingDepth-1:0]  ring_vld_ff;
   logic [opp_pkg::EnvW-1:0]       rd_data_ff;
   logic                           rd_vld_ff;

   logic [opp_pkg::CtlW-1:0]       delay;
   logic [opp_pkg::CtlW-1:0]       lo;
   logic [opp_pkg::SpanW-1:0]      span;
   logic [opp_pkg::SpanW-1:0]      n_avg;
   logic signed [opp_pkg::OffW-1:0] delay_s;
   logic signed [opp_pkg::OffW-1:0] lo_s;
   logic signed [opp_pkg::OffW-1:0] max_lo_s;
   logic signed [opp_pkg::OffW-1:0] max_hi_s;
   logic signed [opp_pkg::OffW-1:0] avg_lo_s;
   logic signed [opp_pkg::OffW-1:0] avg_hi_s;
   logic                           issue;
   logic [opp_pkg::EnvW-1:0]       v;
   logic                           in_max;
   logic                           in_avg;
   logic [opp_pkg::FrameW-1:0]     gap;
   logic                           gap_ok;
   logic                           mean_ok;
   logic                           pick;
   logic                           rsp_free;

   assign delay    = opp_pkg::max4(cfg.post_max, cfg.post_avg);
   assign lo       = opp_pkg::max4(cfg.pre_max, cfg.pre_avg);
   assign span     = {1'b0, delay} + {1'b0, lo};
   assign n_avg    = {1'b0, cfg.pre_avg} + {1'b0, cfg.post_avg} + 5'd1;
   assign delay_s  = $signed({2'b00, delay});
   assign lo_s     = -$signed({2'b00, lo});
   assign max_lo_s = -$signed({2'b00, cfg.pre_max});
   assign max_hi_s = $signed({2'b00, cfg.post_max});
   assign avg_lo_s = -$signed({2'b00, cfg.pre_avg});
   assign avg_hi_s = $signed({2'b00, cfg.post_avg});

   assign q_pop = (state_ff == ST_IDLE) && q_stat.not_empty;
   assign issue = (state_ff == ST_WALK) && !issue_done_ff;

   // entries never written since reset read as zero
   assign v      = rd_vld_ff ? rd_data_ff : '0;
   assign in_max = (d_off_ff >= max_lo_s) && (d_off_ff <= max_hi_s) && (d_off_ff != '0);
   assign in_avg = (d_off_ff >= avg_lo_s) && (d_off_ff <= avg_hi_s);

   assign gap     = cand_frame_ff - last_event_ff;
   assign gap_ok  = !have_event_ff || (gap >= opp_pkg::FrameW'(cfg.min_gap));
   assign mean_ok = {1'b0, prod_c_ff} >= ({1'b0, sum_ff} + {1'b0, prod_m_ff});
   assign pick    = (cand_ff != '0) && !(max_ff > cand_ff) && mean_ok && gap_ok;

   assign rsp_free           = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_strength = rsp_str_ff;
   assign rsp_event_flag     = rsp_flag_ff;

   // ring store: one write at pop, one registered read a cycle during the walk
   always_ff @(posedge clock) begin
      if (q_pop) ring_mem[wp_ff] <= q_item.env_value;
      if (issue) begin
         rd_data_ff <= ring_mem[ptr_ff];
         rd_vld_ff  <= ring_vld_ff[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
      end else if (q_pop) begin
         ring_vld_ff[wp_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wp_ff         <= '0;
         have_event_ff <= 1'b0;
         last_event_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         issue_done_ff <= 1'b0;
         d_valid_ff    <= 1'b0;
      end else begin
         // drop the taken result unless the next one is loaded this cycle
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) rsp_valid_ff <= 1'b0;
         d_valid_ff <= issue;
         unique case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  wp_ff         <= opp_pkg::next_slot(wp_ff);
                  ptr_ff        <= opp_pkg::span_slot(wp_ff, span);
                  off_ff        <= lo_s;
                  cand_frame_ff <= q_item.cand_frame;
                  max_ff        <= '0;
                  sum_ff        <= '0;
                  cand_ff       <= '0;
                  issue_done_ff <= 1'b0;
                  res_flag_ff   <= 1'b0;
                  res_str_ff    <= '0;
                  // warm-up frames skip the walk and report no event
                  state_ff      <= q_item.warm ? ST_DONE : ST_WALK;
               end
            end
            ST_WALK: begin
               if (issue) begin
                  ptr_ff   <= opp_pkg::next_slot(ptr_ff);
                  off_ff   <= off_ff + 1'b1;
                  d_off_ff <= off_ff;
                  if (off_ff == delay_s) issue_done_ff <= 1'b1;
               end
               if (d_valid_ff) begin
                  if (in_max && (v > max_ff)) max_ff <= v;
                  if (in_avg) sum_ff <= sum_ff + opp_pkg::SumW'(v);
                  if (d_off_ff == '0) cand_ff <= v;
                  if (d_off_ff == delay_s) state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               prod_c_ff <= opp_pkg::ProdW'(cand_ff) * opp_pkg::ProdW'(n_avg);
               prod_m_ff <= opp_pkg::ProdW'(cfg.margin) * opp_pkg::ProdW'(n_avg);
               state_ff  <= ST_DECIDE;
            end
            ST_DECIDE: begin
               res_flag_ff <= pick;
               res_str_ff  <= pick ? cand_ff : '0;
               if (pick) begin
                  have_event_ff <= 1'b1;
                  last_event_ff <= cand_frame_ff;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_str_ff   <= res_str_ff;
                  rsp_flag_ff  <= res_flag_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_flag_has_strength: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flag_ff) |-> (rsp_str_ff != '0))
      else $error("event reported with zero strength");

   a_no_flag_no_strength: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_flag_ff) |-> (rsp_str_ff == '0))
      else $error("strength shown without an event");

   a_pick_records_event: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && pick) |=> (have_event_ff && last_event_ff == $past(cand_frame_ff)))
      else $error("picked event not recorded");

   a_walk_in_window: assert property (@(posedge clock) disable iff (reset)
      d_valid_ff |-> (d_off_ff <= delay_s && d_off_ff >= lo_s))
      else $error("walk offset outside window");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_free) |=> (state_ff == ST_DONE))
      else $error("result dropped while output held");
`endif

endmodule

`default_nettype wire

@@ rtl/onset_peak_picker_top.sv @@
// ----------------------------------------------------------------------------
// onset_peak_picker_top: picks onset events from an envelope stream
// Takes one Q4.12 envelope value a frame and returns one result a frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one envelope value per item, taken when req_valid is high and
//            req_stall low. req_stall rises while the two-entry queue is full.
//   rsp_*  : one result per input item, in order; held in an output register
//            until rsp_stall is low. event_flag marks a picked peak and
//            event_strength carries its value, else both are zero.
//   csr_*  : register writes by index (pre_max, post_max, pre_avg, post_avg,
//            margin, min_gap), taken at once. The user must write only while
//            no item is in flight; the block does not enforce this.
// Timing: an item walks offsets -lo to +delay, delay = max(post_max, post_avg),
//   lo = max(pre_max, pre_avg), then passes EVAL, DECIDE and DONE to rsp_valid;
//   the back part takes a new item only when idle. The walk reads the
//   single-port ring once a cycle; warm-up items skip the walk.
// Reset: synchronous; clears the ring (through per-entry valid bits), the
//   frame and event history and loads the default register values.
// A stalled receiver holds the result; the queue then fills and stalls req.
// ----------------------------------------------------------------------------
`default_nettype none

module onset_peak_picker_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [opp_pkg::EnvW-1:0]  req_env_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [opp_pkg::EnvW-1:0]       rsp_event_strength,
   output logic                           rsp_event_flag,
   input  wire logic                      csr_we,
   input  wire logic [opp_pkg::IdxW-1:0]  csr_index,
   input  wire logic [opp_pkg::WideW-1:0] csr_wdata
);

   opp_pkg::cfg_type          cfg_ff;
   opp_pkg::queue_status_type q_stat;
   opp_pkg::item_type         push_item;
   opp_pkg::item_type         head_item;
   logic                      q_push;
   logic                      q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pre_max  <= 4'd3;
         cfg_ff.post_max <= 4'd1;
         cfg_ff.pre_avg  <= 4'd3;
         cfg_ff.post_avg <= 4'd1;
         cfg_ff.margin   <= 16'd205;
         cfg_ff.min_gap  <= 16'd4;
      end else if (csr_we) begin
         unique case (csr_index)
            opp_pkg::CsrPreMax:  cfg_ff.pre_max  <= csr_wdata[opp_pkg::CtlW-1:0];
            opp_pkg::CsrPostMax: cfg_ff.post_max <= csr_wdata[opp_pkg::CtlW-1:0];
            opp_pkg::CsrPreAvg:  cfg_ff.pre_avg  <= csr_wdata[opp_pkg::CtlW-1:0];
            opp_pkg::CsrPostAvg: cfg_ff.post_avg <= csr_wdata[opp_pkg::CtlW-1:0];
            opp_pkg::CsrMargin:  cfg_ff.margin   <= csr_wdata;
            opp_pkg::CsrMinGap:  cfg_ff.min_gap  <= csr_wdata;
            default: ;
         endcase
      end
   end

   opp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_env_value (req_env_value),
      .q_stat        (q_stat),
      .q_push        (q_push),
      .q_item        (push_item)
   );

   opp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   opp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_stat             (q_stat),
      .q_item             (head_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_strength (rsp_event_strength),
      .rsp_event_flag     (rsp_event_flag)
   );

endmodule

`default_nettype wire

@@ bench/onset_peak_picker_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// onset_peak_picker_top_tb: self-checking bench for the onset peak picker
// Streams envelope items through the block under several register settings,
// with random gaps on the request side and random stalls on the result side.
// A scoreboard keeps its own ring, frame history and registers, works out
// the pick for each accepted item and checks every result in order.
// ----------------------------------------------------------------------------

module onset_peak_picker_top_tb;

   typedef struct packed {
      logic [opp_pkg::EnvW-1:0] strength;
      logic                     flag;
   } pick_type;

   class peak_scoreboard;
      logic [opp_pkg::EnvW-1:0]   ring [opp_pkg::RingDepth];
      int                         wpos;
      logic [opp_pkg::FrameW-1:0] frames;
      logic [opp_pkg::FrameW-1:0] last_ev;
      logic                       have_ev;
      logic [opp_pkg::CtlW-1:0]   pre_max;
      logic [opp_pkg::CtlW-1:0]   post_max;
      logic [opp_pkg::CtlW-1:0]   pre_avg;
      logic [opp_pkg::CtlW-1:0]   post_avg;
      logic [opp_pkg::WideW-1:0]  margin;
      logic [opp_pkg::WideW-1:0]  min_gap;
      pick_type                   picks_due [$];
      int                         mismatches;

      function new();
         for (int i = 0; i < opp_pkg::RingDepth; i++) ring[i] = '0;
         wpos       = 0;
         frames     = '0;
         last_ev    = '0;
         have_ev    = 1'b0;
         pre_max    = 4'd3;
         post_max   = 4'd1;
         pre_avg    = 4'd3;
         post_avg   = 4'd1;
         margin     = 16'd205;
         min_gap    = 16'd4;
         mismatches = 0;
      endfunction

      function void set_reg(logic [opp_pkg::IdxW-1:0] idx, logic [opp_pkg::WideW-1:0] val);
         case (idx)
            opp_pkg::CsrPreMax:  pre_max  = val[opp_pkg::CtlW-1:0];
            opp_pkg::CsrPostMax: post_max = val[opp_pkg::CtlW-1:0];
            opp_pkg::CsrPreAvg:  pre_avg  = val[opp_pkg::CtlW-1:0];
            opp_pkg::CsrPostAvg: post_avg = val[opp_pkg::CtlW-1:0];
            opp_pkg::CsrMargin:  margin   = val;
            opp_pkg::CsrMinGap:  min_gap  = val;
            default: ;
         endcase
      endfunction

      // slot of the frame off places from the candidate, delay behind the newest
      function int slot(int delay, int off);
         return (wpos - 1 - delay + off + 4 * opp_pkg::RingDepth) % opp_pkg::RingDepth;
      endfunction

      function int pending();
         return picks_due.size();
      endfunction

      // Store the frame and work out the pick it causes
      function void note_frame(logic [opp_pkg::EnvW-1:0] env);
         int                         delay;
         int                         cnt;
         logic [opp_pkg::EnvW-1:0]   cand;
         longint unsigned            total;
         logic [opp_pkg::FrameW-1:0] cand_frame;
         logic [opp_pkg::FrameW-1:0] gap_frames;
         logic                       ok;
         pick_type                   p;
         ring[wpos] = env;
         wpos       = (wpos + 1) % opp_pkg::RingDepth;
         frames     = frames + 1'b1;
         p          = '0;
         delay      = (post_max > post_avg) ? int'(post_max) : int'(post_avg);
         ok         = (frames > opp_pkg::FrameW'(delay));
         cand       = ring[slot(delay, 0)];
         if (ok && cand == '0) ok = 1'b0;
         if (ok) begin
            for (int i = -int'(pre_max); i <= int'(post_max); i++) begin
               if (i != 0 && ring[slot(delay, i)] > cand) ok = 1'b0;
            end
         end
         if (ok) begin
            total = 0;
            for (int i = -int'(pre_avg); i <= int'(post_avg); i++)
               total += ring[slot(delay, i)];
            cnt = int'(pre_avg) + int'(post_avg) + 1;
            if (longint'(cand) * cnt < total + longint'(margin) * cnt) ok = 1'b0;
         end
         if (ok) begin
            cand_frame = frames - opp_pkg::FrameW'(delay);
            gap_frames = cand_frame - last_ev;
            if (have_ev && gap_frames < opp_pkg::FrameW'(min_gap)) ok = 1'b0;
         end
         if (ok) begin
            last_ev    = cand_frame;
            have_ev    = 1'b1;
            p.strength = cand;
            p.flag     = 1'b1;
         end
         picks_due.push_back(p);
      endfunction

      function void check_pick(logic [opp_pkg::EnvW-1:0] strength, logic flag);
         pick_type p;
         if (picks_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with none due: event_strength %h event_flag %b",
                        $time, strength, flag);
            return;
         end
         p = picks_due.pop_front();
         if (strength !== p.strength || flag !== p.flag) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: event_strength exp %h got %h, event_flag exp %b got %b",
                        $time, p.strength, strength, p.flag, flag);
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [opp_pkg::EnvW-1:0]   req_env_value;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [opp_pkg::EnvW-1:0]   rsp_event_strength;
   logic                       rsp_event_flag;
   logic                       csr_we;
   logic [opp_pkg::IdxW-1:0]   csr_index;
   logic [opp_pkg::WideW-1:0]  csr_wdata;

   peak_scoreboard             sb;
   logic                       burst;
   logic [opp_pkg::EnvW-1:0]   last_env;

   onset_peak_picker_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_env_value      (req_env_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_strength (rsp_event_strength),
      .rsp_event_flag     (rsp_event_flag),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int draw_wait();
      if (burst) return 0;
      if ($urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   // Low noise most often, with spikes, some silence, plateaus and raw values
   function automatic logic [opp_pkg::EnvW-1:0] next_env();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)      last_env = opp_pkg::EnvW'($urandom_range(0, 16'h0300));
      else if (r < 65) last_env = opp_pkg::EnvW'($urandom_range(16'h0800, 16'hFFFF));
      else if (r < 75) last_env = '0;
      else if (r < 85) last_env = opp_pkg::EnvW'($urandom);
      return last_env;
   endfunction

   function automatic logic [opp_pkg::WideW-1:0] pad_ctl(logic [opp_pkg::CtlW-1:0] v);
      logic [opp_pkg::WideW-1:0] r;
      r = opp_pkg::WideW'($urandom);
      r[opp_pkg::CtlW-1:0] = v;
      return r;
   endfunction

   // Enter and leave at a falling edge; valid stays high across back-to-back items
   task automatic send_frame(logic [opp_pkg::EnvW-1:0] v);
      int w;
      w = draw_wait();
      if (w > 0) begin
         req_valid     <= 1'b0;
         req_env_value <= opp_pkg::EnvW'($urandom);
         repeat (w) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_env_value <= v;
      do @(posedge clock); while (req_stall);
      sb.note_frame(v);
      @(negedge clock);
   endtask

   // Hold the sender until every pick has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [opp_pkg::IdxW-1:0] idx, logic [opp_pkg::WideW-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.set_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic program_regs(logic [opp_pkg::CtlW-1:0] pm, logic [opp_pkg::CtlW-1:0] pom,
                               logic [opp_pkg::CtlW-1:0] pa, logic [opp_pkg::CtlW-1:0] poa,
                               logic [opp_pkg::WideW-1:0] mg,
                               logic [opp_pkg::WideW-1:0] gap);
      write_reg(opp_pkg::CsrPreMax, pad_ctl(pm));
      write_reg(opp_pkg::CsrPostMax, pad_ctl(pom));
      write_reg(opp_pkg::CsrPreAvg, pad_ctl(pa));
      write_reg(opp_pkg::CsrPostAvg, pad_ctl(poa));
      write_reg(opp_pkg::CsrMargin, mg);
      write_reg(opp_pkg::CsrMinGap, gap);
      // an index past the last register must change nothing
      write_reg(opp_pkg::CsrMinGap + opp_pkg::IdxW'(1)
                + opp_pkg::IdxW'($urandom_range(0, 1)),
                opp_pkg::WideW'($urandom));
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(int n_items, logic quiet);
      burst = quiet;
      repeat (n_items) send_frame(next_env());
      drain();
      burst = 1'b0;
   endtask

   // Result side: stall a random while before each item, then take it
   initial begin : result_sink
      int w;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         w = draw_wait();
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_pick(rsp_event_strength, rsp_event_flag);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [opp_pkg::EnvW-1:0] directed [] = '{
         16'h0000, 16'h0000, 16'h0800, 16'h0000, 16'h0000,
         16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h1000,
         16'h1000, 16'h0000, 16'h0000, 16'h00C0, 16'h0000,
         16'h0000, 16'h4000, 16'h3000, 16'h5000, 16'h0000,
         16'hAAAA, 16'h5555, 16'h0001, 16'h0000, 16'hFFFF
      };
      sb            = new();
      burst         = 1'b0;
      last_env      = '0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_env_value = '0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: warm-up, lone spikes, plateau, weak peak, close spikes
      foreach (directed[i]) send_frame(directed[i]);
      drain();

      program_regs(4'd0, 4'd0, 4'd0, 4'd0, 16'h0000, 16'h0000);
      run_phase(60, 1'b0);
      program_regs(4'd15, 4'd15, 4'd15, 4'd15, 16'h0000, 16'h0000);
      run_phase(60, 1'b1);
      program_regs(4'd15, 4'd0, 4'd0, 4'd15, 16'h0100, 16'h0002);
      run_phase(60, 1'b0);
      program_regs(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                   16'hFFFF, 16'hFFFF);
      run_phase(40, 1'b0);
      program_regs(4'd3, 4'd2, 4'd4, 4'd1, 16'h0040, 16'hFFFF);
      run_phase(40, 1'b0);
      repeat (4) begin
         program_regs(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                      opp_pkg::WideW'($urandom_range(0, 16'h0800)),
                      opp_pkg::WideW'($urandom_range(0, 12)));
         run_phase(60, $urandom_range(0, 3) == 0);
      end

      repeat (40) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/opp_pkg.sv
rtl/opp_front.sv
rtl/opp_queue.sv
rtl/opp_back.sv
rtl/onset_peak_picker_top.sv
bench/onset_peak_picker_top_tb.sv
